FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define AST_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define AST_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/bfsa_pkg.sv
// Package with constants, types and codes of the best-fit segment allocator.
`timescale 1ns / 1ps
package bfsa_pkg;

   localparam int MAX_REQUESTS = 1023;
   localparam int MAX_SEGMENTS = 1024;
   localparam int ADDR_BITS    = 32;

   localparam int SEG_IDX_W = $clog2(MAX_SEGMENTS);
   localparam int REQ_IDX_W = $clog2(MAX_REQUESTS);
   localparam int CNT_W     = SEG_IDX_W + 1;
   localparam int ITEM_W    = $clog2(MAX_REQUESTS + 1);

   localparam logic [CNT_W-1:0]     SCAN_END  = CNT_W'(MAX_SEGMENTS);
   localparam logic [CNT_W-1:0]     GRANT_END = CNT_W'(MAX_REQUESTS);
   localparam logic [SEG_IDX_W-1:0] SEG_LAST  = SEG_IDX_W'(MAX_SEGMENTS - 1);
   localparam logic [ITEM_W-1:0]    REQ_LIMIT = ITEM_W'(MAX_REQUESTS);

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] start;
      logic [ADDR_BITS-1:0] length;
      logic [31:0]          stamp;
   } seg_type;

   typedef struct packed {
      logic                 live;
      logic [ADDR_BITS-1:0] start;
      logic [ADDR_BITS-1:0] length;
   } grant_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_KILL_A,
      ST_KILL_B,
      ST_ADD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic check;
      logic scan;
      logic kill_a;
      logic kill_b;
      logic add;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic scan_done;
      logic go;
      logic is_alloc;
      logic rsp_busy;
   } dp_status_type;

endpackage

FILE: hdl/bfsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bfsa_ctrl.sv
// Controller state machine sequencing clear, check, scan and table updates.
`timescale 1ns / 1ps
module bfsa_ctrl import bfsa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          csr_valid,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.go) begin
               state_in = ST_SCAN;
            end else if (status.is_alloc) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_KILL_A;
            end
         end
         ST_KILL_A: begin
            cmd.kill_a = 1'b1;
            state_in   = ST_KILL_B;
         end
         ST_KILL_B: begin
            cmd.kill_b = 1'b1;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = status.is_alloc ? ST_RESP : ST_IDLE;
         end
         ST_RESP: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      // a register write restarts the clearing pass
      if (csr_valid) begin
         cmd       = '0;
         req_ready = 1'b0;
         state_in  = ST_CLEAR;
      end
   end

endmodule

FILE: hdl/bfsa_dp.sv
// Datapath: free and grant tables, scan registers, counters and result register.
`timescale 1ns / 1ps
module bfsa_dp import bfsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_cmd,
   input  logic [31:0]          req_alloc_size,
   input  logic [9:0]           req_request_number,
   input  logic                 csr_valid,
   input  logic [31:0]          csr_total_cells,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [31:0]          rsp_start_cell,
   output logic                 rsp_failed,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status
);

   logic [ADDR_BITS-1:0] total_ff, total_in;
   logic [31:0]          insert_ff, insert_in;
   logic [ITEM_W-1:0]    item_cnt_ff, item_cnt_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [SEG_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic                 op_ff, op_in;
   logic [ADDR_BITS-1:0] size_ff, size_in;
   logic [ITEM_W-1:0]    num_ff, num_in;
   logic                 rel_ok_ff, rel_ok_in;
   logic [REQ_IDX_W-1:0] req_idx_ff, req_idx_in;
   logic [ADDR_BITS-1:0] rel_start_ff, rel_start_in;
   logic [ADDR_BITS-1:0] rel_len_ff, rel_len_in;
   logic                 best_found_ff, best_found_in;
   logic [SEG_IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [ADDR_BITS-1:0] best_start_ff, best_start_in;
   logic [ADDR_BITS-1:0] best_len_ff, best_len_in;
   logic [31:0]          best_stamp_ff, best_stamp_in;
   logic                 fr_found_ff, fr_found_in;
   logic [SEG_IDX_W-1:0] fr_idx_ff, fr_idx_in;
   logic                 left_found_ff, left_found_in;
   logic [SEG_IDX_W-1:0] left_idx_ff, left_idx_in;
   logic [ADDR_BITS-1:0] left_start_ff, left_start_in;
   logic [ADDR_BITS-1:0] left_len_ff, left_len_in;
   logic                 right_found_ff, right_found_in;
   logic [SEG_IDX_W-1:0] right_idx_ff, right_idx_in;
   logic [ADDR_BITS-1:0] right_len_ff, right_len_in;
   logic [ADDR_BITS-1:0] res_start_ff, res_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0] rsp_start_ff, rsp_start_in;
   logic                 rsp_failed_ff, rsp_failed_in;

   logic                 free_we;
   logic [SEG_IDX_W-1:0] free_wa;
   seg_type              free_wd;
   logic [$bits(seg_type)-1:0] free_rd;
   seg_type              entry;

   logic                 grant_we;
   logic [REQ_IDX_W-1:0] grant_wa;
   grant_type            grant_wd;
   logic [REQ_IDX_W-1:0] grant_ra;
   logic [$bits(grant_type)-1:0] grant_rd;
   grant_type            grant_q;

   logic                 is_alloc;
   logic                 rel_live;
   logic                 alloc_go;
   logic [ADDR_BITS-1:0] rest;
   logic [ADDR_BITS:0]   entry_end;
   logic [ADDR_BITS:0]   rel_end;
   logic                 slot_found;
   logic [SEG_IDX_W-1:0] slot_idx;
   logic                 add_en;
   logic [ADDR_BITS-1:0] add_start;
   logic [ADDR_BITS-1:0] add_len;

   bfsa_ram #(.WIDTH($bits(seg_type)), .DEPTH(MAX_SEGMENTS)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_we),
      .wr_addr (free_wa),
      .wr_data (free_wd),
      .rd_addr (cnt_ff[SEG_IDX_W-1:0]),
      .rd_data (free_rd)
   );

   bfsa_ram #(.WIDTH($bits(grant_type)), .DEPTH(MAX_REQUESTS)) u_grant_ram (
      .clock   (clock),
      .wr_en   (grant_we),
      .wr_addr (grant_wa),
      .wr_data (grant_wd),
      .rd_addr (grant_ra),
      .rd_data (grant_rd)
   );

   assign entry    = seg_type'(free_rd);
   assign grant_q  = grant_type'(grant_rd);
   assign is_alloc = (op_ff == CMD_ALLOC);
   assign rel_live = !is_alloc && rel_ok_ff && grant_q.live;
   assign alloc_go = is_alloc && (num_ff != '0) && (size_ff != '0);
   assign rest     = best_len_ff - size_ff;
   assign entry_end = {1'b0, entry.start} + {1'b0, entry.length};
   assign rel_end   = {1'b0, rel_start_ff} + {1'b0, rel_len_ff};
   assign grant_ra  = (req_request_number == '0) ? '0
                      : REQ_IDX_W'(req_request_number - 10'd1);

   // lowest free slot once the entries taken by this item are gone
   always_comb begin
      slot_found = fr_found_ff;
      slot_idx   = fr_idx_ff;
      if (is_alloc) begin
         if (best_found_ff && (!slot_found || best_idx_ff < slot_idx)) begin
            slot_found = 1'b1;
            slot_idx   = best_idx_ff;
         end
      end else begin
         if (left_found_ff && (!slot_found || left_idx_ff < slot_idx)) begin
            slot_found = 1'b1;
            slot_idx   = left_idx_ff;
         end
         if (right_found_ff && (!slot_found || right_idx_ff < slot_idx)) begin
            slot_found = 1'b1;
            slot_idx   = right_idx_ff;
         end
      end
   end

   always_comb begin
      if (is_alloc) begin
         add_en    = best_found_ff && (rest != '0);
         add_start = best_start_ff + size_ff;
         add_len   = rest;
      end else begin
         add_en    = slot_found;
         add_start = left_found_ff ? left_start_ff : rel_start_ff;
         add_len   = rel_len_ff + (left_found_ff ? left_len_ff : '0)
                     + (right_found_ff ? right_len_ff : '0);
      end
   end

   // table write ports
   always_comb begin
      free_we  = 1'b0;
      free_wa  = cnt_ff[SEG_IDX_W-1:0];
      free_wd  = '0;
      grant_we = 1'b0;
      grant_wa = cnt_ff[REQ_IDX_W-1:0];
      grant_wd = '0;
      if (cmd.clear) begin
         free_we  = 1'b1;
         if (cnt_ff == '0) begin
            free_wd.valid  = (total_ff != '0);
            free_wd.start  = ADDR_BITS'(1);
            free_wd.length = total_ff;
         end
         grant_we = (cnt_ff < GRANT_END);
      end
      if (cmd.check && rel_live) begin
         grant_we = 1'b1;
         grant_wa = req_idx_ff;
         grant_wd = '{live: 1'b0, start: grant_q.start, length: grant_q.length};
      end
      if (cmd.kill_a) begin
         if (is_alloc) begin
            free_we  = best_found_ff;
            free_wa  = best_idx_ff;
            grant_we = best_found_ff;
            grant_wa = REQ_IDX_W'(num_ff - 1'b1);
            grant_wd = '{live: 1'b1, start: best_start_ff, length: size_ff};
         end else begin
            free_we = left_found_ff;
            free_wa = left_idx_ff;
         end
      end
      if (cmd.kill_b) begin
         free_we = !is_alloc && right_found_ff;
         free_wa = right_idx_ff;
      end
      if (cmd.add) begin
         free_we = add_en;
         free_wa = slot_idx;
         free_wd = '{valid: 1'b1, start: add_start, length: add_len, stamp: insert_ff};
      end
   end

   always_comb begin
      total_in       = total_ff;
      insert_in      = insert_ff;
      item_cnt_in    = item_cnt_ff;
      cnt_in         = cnt_ff;
      rd_pend_in     = 1'b0;
      rd_idx_in      = cnt_ff[SEG_IDX_W-1:0];
      op_in          = op_ff;
      size_in        = size_ff;
      num_in         = num_ff;
      rel_ok_in      = rel_ok_ff;
      req_idx_in     = req_idx_ff;
      rel_start_in   = rel_start_ff;
      rel_len_in     = rel_len_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_start_in  = best_start_ff;
      best_len_in    = best_len_ff;
      best_stamp_in  = best_stamp_ff;
      fr_found_in    = fr_found_ff;
      fr_idx_in      = fr_idx_ff;
      left_found_in  = left_found_ff;
      left_idx_in    = left_idx_ff;
      left_start_in  = left_start_ff;
      left_len_in    = left_len_ff;
      right_found_in = right_found_ff;
      right_idx_in   = right_idx_ff;
      right_len_in   = right_len_ff;
      res_start_in   = res_start_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_start_in   = rsp_start_ff;
      rsp_failed_in  = rsp_failed_ff;

      if (cmd.clear) begin
         cnt_in    = cnt_ff + 1'b1;
         insert_in = 32'd1;
      end

      if (cmd.accept) begin
         cnt_in         = '0;
         op_in          = req_cmd;
         size_in        = req_alloc_size;
         rel_ok_in      = (req_request_number != '0);
         req_idx_in     = grant_ra;
         best_found_in  = 1'b0;
         fr_found_in    = 1'b0;
         left_found_in  = 1'b0;
         right_found_in = 1'b0;
         res_start_in   = '0;
         if (item_cnt_ff < REQ_LIMIT) begin
            item_cnt_in = item_cnt_ff + 1'b1;
            num_in      = item_cnt_ff + 1'b1;
         end else begin
            num_in = '0;
         end
      end

      if (cmd.check && rel_live) begin
         rel_start_in = grant_q.start;
         rel_len_in   = grant_q.length;
      end

      // issue one read per cycle, evaluate the entry that comes back
      if (cmd.scan && cnt_ff < SCAN_END) begin
         cnt_in     = cnt_ff + 1'b1;
         rd_pend_in = 1'b1;
      end

      if (rd_pend_ff) begin
         if (!entry.valid && !fr_found_ff) begin
            fr_found_in = 1'b1;
            fr_idx_in   = rd_idx_ff;
         end
         if (entry.valid) begin
            if (is_alloc) begin
               if (entry.length >= size_ff &&
                   (!best_found_ff || entry.length < best_len_ff ||
                    (entry.length == best_len_ff && entry.stamp < best_stamp_ff))) begin
                  best_found_in = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_start_in = entry.start;
                  best_len_in   = entry.length;
                  best_stamp_in = entry.stamp;
               end
            end else if (entry_end == {1'b0, rel_start_ff}) begin
               left_found_in = 1'b1;
               left_idx_in   = rd_idx_ff;
               left_start_in = entry.start;
               left_len_in   = entry.length;
            end else if ({1'b0, entry.start} == rel_end) begin
               right_found_in = 1'b1;
               right_idx_in   = rd_idx_ff;
               right_len_in   = entry.length;
            end
         end
      end

      if (cmd.kill_a && is_alloc && best_found_ff) begin
         res_start_in = best_start_ff;
      end

      if (cmd.add && add_en) begin
         insert_in = insert_ff + 32'd1;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_start_in  = res_start_ff;
         rsp_failed_in = (res_start_ff == '0);
      end

      if (csr_valid) begin
         total_in = csr_total_cells;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '1;
         insert_ff    <= 32'd1;
         item_cnt_ff  <= '0;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         insert_ff    <= insert_in;
         item_cnt_ff  <= item_cnt_in;
         cnt_ff       <= cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      op_ff          <= op_in;
      size_ff        <= size_in;
      num_ff         <= num_in;
      rel_ok_ff      <= rel_ok_in;
      req_idx_ff     <= req_idx_in;
      rel_start_ff   <= rel_start_in;
      rel_len_ff     <= rel_len_in;
      best_found_ff  <= best_found_in;
      best_idx_ff    <= best_idx_in;
      best_start_ff  <= best_start_in;
      best_len_ff    <= best_len_in;
      best_stamp_ff  <= best_stamp_in;
      fr_found_ff    <= fr_found_in;
      fr_idx_ff      <= fr_idx_in;
      left_found_ff  <= left_found_in;
      left_idx_ff    <= left_idx_in;
      left_start_ff  <= left_start_in;
      left_len_ff    <= left_len_in;
      right_found_ff <= right_found_in;
      right_idx_ff   <= right_idx_in;
      right_len_ff   <= right_len_in;
      res_start_ff   <= res_start_in;
      rsp_start_ff   <= rsp_start_in;
      rsp_failed_ff  <= rsp_failed_in;
   end

   assign status.clear_done = cmd.clear && (cnt_ff[SEG_IDX_W-1:0] == SEG_LAST);
   assign status.scan_done  = (cnt_ff == SCAN_END) && !rd_pend_ff;
   assign status.go         = alloc_go || rel_live;
   assign status.is_alloc   = is_alloc;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_start_cell = rsp_start_ff;
   assign rsp_failed     = rsp_failed_ff;

endmodule

FILE: hdl/best_fit_segment_allocator.sv
// Top level of the best-fit segment allocator: controller plus datapath.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_cmd, req_alloc_size, req_request_number
//   rsp       out        rsp_valid/rsp_ready   rsp_start_cell, rsp_failed
//   csr       in         csr_valid/csr_ready   csr_total_cells
//
// An item that searches the free table first looks up the grant table, then reads
// all 1024 free-table entries through the one read port of the free RAM, then
// updates the tables. An allocation that fails up front skips the scan and goes to
// the result; an ignored release skips the scan and gives no result.
// After reset and after each csr write a clearing pass over all 1024 free-table
// entries runs; req is not taken during it. One item is in work at a time; a result
// waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module best_fit_segment_allocator import bfsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_alloc_size,
   input  logic [9:0]  req_request_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_start_cell,
   output logic        rsp_failed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_total_cells
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   bfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .status    (status),
      .cmd       (cmd)
   );

   bfsa_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_alloc_size     (req_alloc_size),
      .req_request_number (req_request_number),
      .csr_valid          (csr_valid),
      .csr_total_cells    (csr_total_cells),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_start_cell     (rsp_start_cell),
      .rsp_failed         (rsp_failed),
      .cmd                (cmd),
      .status             (status)
   );

   `AST_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)
   `AST_NEXT(a_cfg_clears, clock, reset, csr_valid, !req_ready)
   `AST_SAME(a_fail_code, clock, reset, rsp_valid, rsp_failed == (rsp_start_cell == 32'd0))

endmodule

FILE: test/tb.sv
// Self-checking testbench for the best-fit segment allocator.
`timescale 1ns / 1ps
module tb;
   import bfsa_pkg::*;

   typedef struct {
      logic [31:0] start_cell;
      logic        failed;
   } grant_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CMD_ALLOC;
   logic [31:0] req_alloc_size = '0;
   logic [9:0]  req_request_number = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_start_cell;
   logic        rsp_failed;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_total_cells = '0;

   best_fit_segment_allocator dut (.*);

   always #6 clock = ~clock;

   // Allocator model state
   logic [63:0] seg_start [MAX_SEGMENTS];
   logic [63:0] seg_len   [MAX_SEGMENTS];
   bit          seg_used  [MAX_SEGMENTS];
   logic [31:0] seg_stamp [MAX_SEGMENTS];
   logic [63:0] owned_start [MAX_REQUESTS];
   logic [63:0] owned_len   [MAX_REQUESTS];
   bit          owned_live  [MAX_REQUESTS];
   int unsigned items_seen = 0;
   logic [31:0] next_stamp;
   logic [31:0] cells_total = 32'hFFFF_FFFF;

   grant_result_type expected_grants[$];
   int unsigned      live_requests[$];
   int unsigned      failures = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_stall_pct = 0;

   function automatic void add_free(logic [63:0] s, logic [63:0] l);
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         if (!seg_used[i]) begin
            seg_start[i] = s;
            seg_len[i]   = l;
            seg_used[i]  = 1'b1;
            seg_stamp[i] = next_stamp;
            next_stamp++;
            return;
         end
      end
   endfunction

   function automatic void reinit_memory();
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         seg_used[i] = 1'b0;
         seg_stamp[i] = '0;
      end
      for (int i = 0; i < MAX_REQUESTS; i++) owned_live[i] = 1'b0;
      if (cells_total != 0) begin
         seg_start[0] = 64'd1;
         seg_len[0]   = {32'd0, cells_total};
         seg_used[0]  = 1'b1;
      end
      next_stamp = 32'd1;
   endfunction

   function automatic logic [63:0] carve_best_fit(logic [63:0] size);
      int best;
      logic [63:0] s;
      best = -1;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         if (!seg_used[i] || seg_len[i] < size) continue;
         if (best < 0 || seg_len[i] < seg_len[best] ||
             (seg_len[i] == seg_len[best] && seg_stamp[i] < seg_stamp[best]))
            best = i;
      end
      if (best < 0) return 64'd0;
      s = seg_start[best];
      seg_used[best] = 1'b0;
      if (seg_len[best] > size) add_free(s + size, seg_len[best] - size);
      return s;
   endfunction

   function automatic void return_cells(logic [63:0] s, logic [63:0] l);
      logic [63:0] ns, nl;
      ns = s;
      nl = l;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         if (!seg_used[i]) continue;
         if (seg_start[i] + seg_len[i] == s) begin
            ns = seg_start[i];
            nl += seg_len[i];
            seg_used[i] = 1'b0;
         end else if (seg_start[i] == s + l) begin
            nl += seg_len[i];
            seg_used[i] = 1'b0;
         end
      end
      add_free(ns, nl);
   endfunction

   // Advance the model by one item; queue a result for allocations.
   function automatic void predict_item(logic cmd, logic [31:0] size, logic [9:0] num);
      int unsigned seq;
      logic [63:0] s;
      grant_result_type r;
      seq = 0;
      s = '0;
      if (items_seen < MAX_REQUESTS) begin
         items_seen++;
         seq = items_seen;
      end
      if (cmd == CMD_RELEASE) begin
         if (num >= 1 && num <= MAX_REQUESTS && owned_live[num-1]) begin
            owned_live[num-1] = 1'b0;
            return_cells(owned_start[num-1], owned_len[num-1]);
         end
         return;
      end
      if (seq != 0 && size != 0) s = carve_best_fit({32'd0, size});
      if (s != 0) begin
         owned_start[seq-1] = s;
         owned_len[seq-1]   = {32'd0, size};
         owned_live[seq-1]  = 1'b1;
         live_requests.push_back(seq);
      end
      r.start_cell = s[31:0];
      r.failed     = (s == 0);
      expected_grants.push_back(r);
   endfunction

   task automatic send_item(logic cmd, logic [31:0] size, logic [9:0] num);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= cmd;
      req_alloc_size     <= size;
      req_request_number <= num;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      predict_item(cmd, size, num);
   endtask

   // Hold off until every result is in and any trailing release has finished.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (1100) @(posedge clock);
   endtask

   task automatic write_total(logic [31:0] cells);
      drain();
      csr_valid       <= 1'b1;
      csr_total_cells <= cells;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      cells_total = cells;
      reinit_memory();
      live_requests.delete();
   endtask

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // Check each accepted result against the oldest expectation.
   always @(negedge clock) begin
      grant_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_grants.size() == 0) begin
            $error("unexpected result: start_cell %0d failed %0d", rsp_start_cell, rsp_failed);
            failures++;
         end else begin
            e = expected_grants.pop_front();
            if (rsp_start_cell !== e.start_cell) begin
               $error("start_cell: expected %0d, actual %0d", e.start_cell, rsp_start_cell);
               failures++;
            end
            if (rsp_failed !== e.failed) begin
               $error("failed: expected %0d, actual %0d", e.failed, rsp_failed);
               failures++;
            end
         end
      end
   end

   task automatic test_directed();
      // wide memory from reset: zero size, unit size, full size, near-full size, then releases and tiny memories
      send_item(CMD_ALLOC, 32'd0, 10'd0);
      send_item(CMD_ALLOC, 32'd1, 10'd0);
      send_item(CMD_ALLOC, 32'hFFFF_FFFF, 10'd0);
      send_item(CMD_ALLOC, 32'hFFFF_FFFE, 10'd0);
      send_item(CMD_RELEASE, 32'hFFFF_FFFF, 10'd0);
      send_item(CMD_RELEASE, 32'd0, 10'd1023);
      send_item(CMD_RELEASE, 32'd0, 10'd2);
      send_item(CMD_RELEASE, 32'd0, 10'd2);
      send_item(CMD_RELEASE, 32'd0, 10'd1);
      send_item(CMD_RELEASE, 32'd0, 10'd5);
      send_item(CMD_ALLOC, 32'd1, 10'h3FF);
      send_item(CMD_RELEASE, 32'd0, 10'd4);
      send_item(CMD_ALLOC, 32'hFFFF_FFFF, 10'd0);
      write_total(32'd1);
      send_item(CMD_ALLOC, 32'd1, 10'd0);
      send_item(CMD_ALLOC, 32'd1, 10'd0);
      write_total(32'd0);
      send_item(CMD_ALLOC, 32'd1, 10'd0);
      write_total(32'd10);
      // carve three, free middle then first to merge, refit across the merge
      send_item(CMD_ALLOC, 32'd3, 10'd0);
      send_item(CMD_ALLOC, 32'd3, 10'd0);
      send_item(CMD_ALLOC, 32'd3, 10'd0);
      send_item(CMD_RELEASE, 32'd0, 10'(items_seen - 1));
      send_item(CMD_RELEASE, 32'd0, 10'(items_seen - 3));
      send_item(CMD_ALLOC, 32'd6, 10'd0);
      send_item(CMD_ALLOC, 32'd2, 10'd0);
   endtask

   task automatic test_random(logic [31:0] cells, int unsigned count, bit pause_once);
      int unsigned k, pick, roll;
      logic [31:0] size;
      write_total(cells);
      for (k = 0; k < count; k++) begin
         if (pause_once && k == count / 2) drain();
         roll = $urandom_range(99);
         if (roll < 45) begin
            size = (cells == 0) ? 32'd1 : 32'($urandom_range(1, cells / 4 + 1));
            send_item(CMD_ALLOC, size, 10'($urandom));
         end else if (roll < 80 && live_requests.size() != 0) begin
            pick = $urandom_range(live_requests.size() - 1);
            send_item(CMD_RELEASE, $urandom, 10'(live_requests[pick]));
            live_requests.delete(pick);
         end else if (roll < 90) begin
            send_item(CMD_ALLOC, ($urandom_range(3) == 0) ? 32'd0 : $urandom, 10'($urandom));
         end else begin
            send_item(CMD_RELEASE, $urandom, 10'($urandom));
         end
      end
   endtask

   initial begin
      reinit_memory();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(32'd64, 330, 1'b1);
      send_idle_pct = 65;
      test_random(32'd200, 330, 1'b0);
      send_idle_pct = 0;
      recv_stall_pct = 65;
      test_random(32'd1000, 330, 1'b0);
      send_idle_pct = 10;
      recv_stall_pct = 10;
      test_random(32'hFFFF_FFFF, 330, 1'b0);
      drain();
      failures += expected_grants.size();
      if (failures == 0)
         $display("best_fit_segment_allocator: match");
      else
         $display("best_fit_segment_allocator: mismatch");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("best_fit_segment_allocator: mismatch");
      $finish;
   end

endmodule
